// ----- rtl/chd_pkg.sv -----
// ----------------------------------------------------------------------------
// chd_pkg - shared types and constants for the compass heading block
// Widths, fixed-point formats, angle codes, the CORDIC arctangent table and rotation.
// ----------------------------------------------------------------------------
package chd_pkg;

    // sample and pipeline sizing
    localparam int SAMPLE_WIDTH  = 12;
    localparam int CORDIC_STAGES = 16;
    localparam int TABLE_SIZE    = 24;

    // guard bits put the magnitude msb near bit 39; three bits of headroom on top
    localparam int GUARD_SHIFT = 40 - SAMPLE_WIDTH;
    localparam int VEC_WIDTH   = 43;

    // angles in degrees with 16 fractional bits
    localparam int FRAC_BITS   = 16;
    localparam int ZACC_WIDTH  = 26;
    localparam int ANG_WIDTH   = 23;
    localparam int HEAD_WIDTH  = 25;
    localparam int DEG_WIDTH   = 9;

    // stream widths, rounded up to whole bytes
    localparam int IN_DATA_WIDTH  = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int OUT_DATA_WIDTH = ((DEG_WIDTH + 7) / 8) * 8;

    // fixed angles in Q16 degrees
    localparam logic [ANG_WIDTH-1:0]  ANGLE_45  = ANG_WIDTH'(45 << FRAC_BITS);
    localparam logic [ANG_WIDTH-1:0]  ANGLE_90  = ANG_WIDTH'(90 << FRAC_BITS);
    localparam logic [HEAD_WIDTH-1:0] ANGLE_180 = HEAD_WIDTH'(180 << FRAC_BITS);
    localparam logic [HEAD_WIDTH-1:0] ANGLE_360 = HEAD_WIDTH'(360 << FRAC_BITS);
    localparam logic [DEG_WIDTH-1:0]  DEG_MAX   = DEG_WIDTH'(359);

    // how the first-quadrant angle is obtained
    localparam logic [1:0] ANG_CORDIC = 2'd0;
    localparam logic [1:0] ANG_ZERO   = 2'd1;
    localparam logic [1:0] ANG_RIGHT  = 2'd2;
    localparam logic [1:0] ANG_HALF   = 2'd3;

    typedef logic signed [VEC_WIDTH-1:0]  t_vec;
    typedef logic signed [ZACC_WIDTH-1:0] t_zacc;

    // quadrant and angle source, carried alongside the vector
    typedef struct packed {
        logic       neg_x;
        logic       neg_y;
        logic [1:0] code;
    } t_side;

    typedef struct packed {
        t_vec  x;
        t_vec  y;
        t_zacc z;
        t_side side;
    } t_cordic;

    // atan(2^-i) in Q16 degrees, rounded to nearest
    localparam t_zacc ATAN_TABLE [TABLE_SIZE] = '{
        26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
        26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
        26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
        26'sd917,     26'sd458,     26'sd229,    26'sd115,
        26'sd57,      26'sd29,      26'sd14,     26'sd7,
        26'sd4,       26'sd2,       26'sd1,      26'sd0
    };

    // one vectoring rotation; drives y toward zero
    function automatic t_cordic cordic_iter(input t_cordic s, input int stage);
        t_vec    vx;
        t_vec    vy;
        t_vec    dx;
        t_vec    dy;
        t_zacc   vz;
        t_cordic r;
        vx = s.x;
        vy = s.y;
        vz = s.z;
        dx = vy >>> stage;
        dy = vx >>> stage;
        r  = s;
        if (!vy[VEC_WIDTH-1] && (vy != '0)) begin
            r.x = vx + dx;
            r.y = vy - dy;
            r.z = vz + ATAN_TABLE[stage];
        end else begin
            r.x = vx - dx;
            r.y = vy + dy;
            r.z = vz - ATAN_TABLE[stage];
        end
        return r;
    endfunction

endpackage

// ----- rtl/chd_cordic_pipe.sv -----
// ----------------------------------------------------------------------------
// chd_cordic_pipe - unrolled vectoring CORDIC
// One rotation per register stage, per-stage valid bits and a ready chain
// so bubbles collapse and a stall holds a full stage only while all stages after it are full.
// ----------------------------------------------------------------------------
module chd_cordic_pipe
    import chd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_cordic i_data,
    output logic    o_valid,
    input  logic    i_ready,
    output t_cordic o_data
);

    logic    r_valid [CORDIC_STAGES];
    t_cordic r_data  [CORDIC_STAGES];
    logic    stage_en [CORDIC_STAGES];

    // a stage loads when empty or when its content moves on
    assign stage_en[CORDIC_STAGES-1] = !r_valid[CORDIC_STAGES-1] || i_ready;

    genvar k;
    generate
        for (k = 0; k < CORDIC_STAGES - 1; k++) begin : g_ready
            assign stage_en[k] = !r_valid[k] || stage_en[k+1];
        end

        for (k = 0; k < CORDIC_STAGES; k++) begin : g_stage
            logic    prev_valid;
            t_cordic prev_data;

            if (k == 0) begin : g_first
                assign prev_valid = i_valid;
                assign prev_data  = i_data;
            end else begin : g_next
                assign prev_valid = r_valid[k-1];
                assign prev_data  = r_data[k-1];
            end

            // valid bit
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[k] <= 1'b0;
                end else if (stage_en[k]) begin
                    r_valid[k] <= prev_valid;
                end
            end

            // rotation k
            always_ff @(posedge i_clk) begin
                if (stage_en[k]) begin
                    r_data[k] <= cordic_iter(prev_data, k);
                end
            end
        end
    endgenerate

    assign o_ready = stage_en[0];
    assign o_valid = r_valid[CORDIC_STAGES-1];
    assign o_data  = r_data[CORDIC_STAGES-1];

endmodule

// ----- rtl/compass_heading_degrees.sv -----
// Registers: front stage, one per CORDIC rotation (which sets the depth), angle, output.
// Throughput: one sample per cycle while the output side does not stall.
// Stalls hold each full stage in place; empty stages keep accepting new samples.
// Reset (synchronous, active low) clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// compass_heading_degrees - magnetometer X/Y to compass heading
// atan2(y, x) in whole degrees 0..359 via a pipelined vectoring CORDIC, with
// axis, diagonal and zero cases resolved up front and the quadrant applied last.
// ----------------------------------------------------------------------------
module compass_heading_degrees
    import chd_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [IN_DATA_WIDTH-1:0]  i_s_tdata,   // x_reading [11:0], y_reading [23:12]
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic [OUT_DATA_WIDTH-1:0] o_m_tdata    // heading_degrees [8:0], zero pad above
);

    // front stage: magnitudes, signs, special cases
    logic                          r_f_valid;
    t_cordic                       r_f_data;
    t_cordic                       n_f_data;
    logic signed [SAMPLE_WIDTH-1:0] sx;
    logic signed [SAMPLE_WIDTH-1:0] sy;
    logic [SAMPLE_WIDTH-1:0]        ax;
    logic [SAMPLE_WIDTH-1:0]        ay;

    // cordic pipe handshake
    logic    pipe_ready;
    logic    pipe_valid;
    t_cordic pipe_data;

    // angle stage
    logic                 r_a_valid;
    logic [ANG_WIDTH-1:0] r_a_angle;
    logic [ANG_WIDTH-1:0] n_a_angle;
    t_side                r_a_side;
    logic [ANG_WIDTH-1:0] z_clamped;

    // output stage
    logic                  r_o_valid;
    logic [DEG_WIDTH-1:0]  r_o_deg;
    logic [DEG_WIDTH-1:0]  n_o_deg;
    logic [HEAD_WIDTH-1:0] head;
    logic [HEAD_WIDTH-1:0] a_ext;
    logic [DEG_WIDTH-1:0]  head_deg;

    logic en_o;
    logic en_a;
    logic en_f;

    // stage enables, back to front
    assign en_o       = !r_o_valid || i_m_tready;
    assign en_a       = !r_a_valid || en_o;
    assign en_f       = !r_f_valid || pipe_ready;
    assign o_s_tready = en_f;

    // sign-magnitude split and angle source
    always_comb begin
        sx = i_s_tdata[SAMPLE_WIDTH-1:0];
        sy = i_s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
        ax = sx[SAMPLE_WIDTH-1] ? -sx : sx;
        ay = sy[SAMPLE_WIDTH-1] ? -sy : sy;
        n_f_data.side.neg_x = sx[SAMPLE_WIDTH-1];
        n_f_data.side.neg_y = sy[SAMPLE_WIDTH-1];
        priority if (ay == '0) begin
            n_f_data.side.code = ANG_ZERO;
        end else if (ax == '0) begin
            n_f_data.side.code = ANG_RIGHT;
        end else if (ax == ay) begin
            n_f_data.side.code = ANG_HALF;
        end else begin
            n_f_data.side.code = ANG_CORDIC;
        end
        n_f_data.x = {{(VEC_WIDTH-SAMPLE_WIDTH-GUARD_SHIFT){1'b0}}, ax, {GUARD_SHIFT{1'b0}}};
        n_f_data.y = {{(VEC_WIDTH-SAMPLE_WIDTH-GUARD_SHIFT){1'b0}}, ay, {GUARD_SHIFT{1'b0}}};
        n_f_data.z = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (en_f) begin
            r_f_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_f) begin
            r_f_data <= n_f_data;
        end
    end

    // rotations
    chd_cordic_pipe u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_f_valid),
        .o_ready (pipe_ready),
        .i_data  (r_f_data),
        .o_valid (pipe_valid),
        .i_ready (en_a),
        .o_data  (pipe_data)
    );

    // clamp the accumulated angle to 0..90 and pick the first-quadrant angle
    always_comb begin
        priority if (pipe_data.z[ZACC_WIDTH-1]) begin
            z_clamped = '0;
        end else if (pipe_data.z > $signed({{(ZACC_WIDTH-ANG_WIDTH){1'b0}}, ANGLE_90})) begin
            z_clamped = ANGLE_90;
        end else begin
            z_clamped = pipe_data.z[ANG_WIDTH-1:0];
        end
        unique case (pipe_data.side.code)
            ANG_ZERO:  n_a_angle = '0;
            ANG_RIGHT: n_a_angle = ANGLE_90;
            ANG_HALF:  n_a_angle = ANGLE_45;
            default:   n_a_angle = z_clamped;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en_a) begin
            r_a_valid <= pipe_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_angle <= n_a_angle;
            r_a_side  <= pipe_data.side;
        end
    end

    // quadrant placement, truncation to whole degrees, saturation at 359
    always_comb begin
        a_ext = {{(HEAD_WIDTH-ANG_WIDTH){1'b0}}, r_a_angle};
        priority if (!r_a_side.neg_x && !r_a_side.neg_y) begin
            head = a_ext;
        end else if (r_a_side.neg_x && !r_a_side.neg_y) begin
            head = ANGLE_180 - a_ext;
        end else if (r_a_side.neg_x) begin
            head = ANGLE_180 + a_ext;
        end else begin
            head = ANGLE_360 - a_ext;
        end
        head_deg = head[HEAD_WIDTH-1:FRAC_BITS];
        n_o_deg  = (head_deg > DEG_MAX) ? DEG_MAX : head_deg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en_o) begin
            r_o_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_o) begin
            r_o_deg <= n_o_deg;
        end
    end

    // result transfer
    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {{(OUT_DATA_WIDTH-DEG_WIDTH){1'b0}}, r_o_deg};

endmodule

// ----- sim/compass_heading_degrees_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// compass_heading_degrees_tb - self-checking bench for the compass heading block
// Streams X/Y samples through the heading pipeline under random idle and stall
// patterns. Each result is checked in order against a fixed-point atan2
// predictor, or against a typed value for axis, diagonal and zero probes.
// ----------------------------------------------------------------------------
module compass_heading_degrees_tb;
    import chd_pkg::*;

    localparam int ITEMS_PER_PHASE = 417;
    localparam int DRAIN_CYCLES    = CORDIC_STAGES + 3 + 20;
    localparam int PREDICT         = -1;
    localparam longint DEG_ONE     = 65536;

    // atan(2^-i) in degrees, 16 fractional bits
    localparam longint ARCTAN_Q16 [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] x;
        logic signed [SAMPLE_WIDTH-1:0] y;
        int                             heading;
    } t_probe;

    // directed probes; PREDICT rows go through the predictor
    localparam int NUM_PROBES = 23;
    localparam t_probe PROBES [NUM_PROBES] = '{
        '{0, 0, 0},            // zero by zero
        '{5, 0, 0},
        '{-5, 0, 180},
        '{0, 7, 90},
        '{0, -7, 270},
        '{2047, 0, 0},
        '{-2048, 0, 180},
        '{0, 2047, 90},
        '{0, -2048, 270},
        '{2047, 2047, 45},
        '{-2047, 2047, 135},
        '{-2048, -2048, 225},
        '{1, -1, 315},
        '{2047, -1, PREDICT},  // just under a full turn
        '{-2048, -1, PREDICT},
        '{-2048, 1, PREDICT},
        '{1, 2047, PREDICT},
        '{1, -2048, PREDICT},
        '{-1, -2048, PREDICT},
        '{2047, 1, PREDICT},
        '{1000, -577, PREDICT},
        '{-3, 4, PREDICT},
        '{2047, -2048, PREDICT}
    };

    logic                      i_clk      = 1'b0;
    logic                      i_rst_n    = 1'b0;
    logic                      i_s_tvalid = 1'b0;
    logic [IN_DATA_WIDTH-1:0]  i_s_tdata  = '0;   // x_reading [11:0], y_reading [23:12]
    logic                      i_m_tready = 1'b0;
    logic                      o_s_tready;
    logic                      o_m_tvalid;
    logic [OUT_DATA_WIDTH-1:0] o_m_tdata;          // heading_degrees [8:0], zero pad above

    int                   send_idle_pct = 0;
    int                   stall_pct     = 0;
    int                   typed_heading = PREDICT;
    int                   error_count   = 0;
    logic [DEG_WIDTH-1:0] heading_queue [$];

    compass_heading_degrees uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    // heading of one sample: vectoring cordic on magnitudes, then quadrant fix-up
    function automatic logic [DEG_WIDTH-1:0] heading_of(
        input logic signed [SAMPLE_WIDTH-1:0] x,
        input logic signed [SAMPLE_WIDTH-1:0] y
    );
        longint sx;
        longint sy;
        longint ax;
        longint ay;
        longint cx;
        longint cy;
        longint dx;
        longint dy;
        longint z;
        longint a;
        longint h;
        sx = x;
        sy = y;
        ax = (sx < 0) ? -sx : sx;
        ay = (sy < 0) ? -sy : sy;
        if (ax == 0 && ay == 0) begin
            return '0;
        end
        if (ax == 0) begin
            a = 90 * DEG_ONE;
        end else if (ay == 0) begin
            a = 0;
        end else if (ax == ay) begin
            a = 45 * DEG_ONE;
        end else begin
            cx = ax <<< (40 - SAMPLE_WIDTH);
            cy = ay <<< (40 - SAMPLE_WIDTH);
            z  = 0;
            for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
                dx = cy >>> i;
                dy = cx >>> i;
                if (cy > 0) begin
                    cx = cx + dx;
                    cy = cy - dy;
                    z  = z + ARCTAN_Q16[i];
                end else begin
                    cx = cx - dx;
                    cy = cy + dy;
                    z  = z - ARCTAN_Q16[i];
                end
            end
            if (z < 0) z = 0;
            if (z > 90 * DEG_ONE) z = 90 * DEG_ONE;
            a = z;
        end
        if (sx >= 0 && sy >= 0) begin
            h = a;
        end else if (sx < 0 && sy >= 0) begin
            h = 180 * DEG_ONE - a;
        end else if (sx < 0) begin
            h = 180 * DEG_ONE + a;
        end else begin
            h = 360 * DEG_ONE - a;
        end
        if (h < 0) h = 0;
        h = h >>> 16;
        if (h > 359) h = 359;
        return DEG_WIDTH'(h);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        error_count++;
    endtask

    // one input transfer, with random idle cycles ahead of it
    task automatic send_sample(
        input logic signed [SAMPLE_WIDTH-1:0] x,
        input logic signed [SAMPLE_WIDTH-1:0] y,
        input int                             typed
    );
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid    <= 1'b1;
        i_s_tdata     <= IN_DATA_WIDTH'({y, x});
        typed_heading <= typed;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    // receiver back-pressure
    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // record expectations on input transfers, check output transfers
    always @(posedge i_clk) begin
        logic signed [SAMPLE_WIDTH-1:0] in_x;
        logic signed [SAMPLE_WIDTH-1:0] in_y;
        logic [DEG_WIDTH-1:0]           want;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                in_x = i_s_tdata[SAMPLE_WIDTH-1:0];
                in_y = i_s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
                if (typed_heading == PREDICT) begin
                    heading_queue.push_back(heading_of(in_x, in_y));
                end else begin
                    heading_queue.push_back(DEG_WIDTH'(typed_heading));
                end
            end
            if (o_m_tvalid && i_m_tready) begin
                if (heading_queue.size() == 0) begin
                    report_mismatch($sformatf("unexpected output transfer, heading %0d",
                                              o_m_tdata[DEG_WIDTH-1:0]));
                end else begin
                    want = heading_queue.pop_front();
                    if (o_m_tdata[DEG_WIDTH-1:0] !== want) begin
                        report_mismatch($sformatf("heading_degrees got %0d, expected %0d",
                                                  o_m_tdata[DEG_WIDTH-1:0], want));
                    end
                end
            end
        end
    end

    // stimulus
    initial begin
        logic signed [SAMPLE_WIDTH-1:0] rx;
        logic signed [SAMPLE_WIDTH-1:0] ry;
        logic signed [SAMPLE_WIDTH-1:0] swap;
        int                             kind;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 14;
        stall_pct     = 86;
        foreach (PROBES[i]) begin
            send_sample(PROBES[i].x, PROBES[i].y, PROBES[i].heading);
        end

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 86 : 0;
            stall_pct     = (phase == 0) ? 86 : (phase == 1) ? 14 : 0;
            repeat (ITEMS_PER_PHASE) begin
                kind = $urandom_range(0, 9);
                rx   = SAMPLE_WIDTH'($urandom);
                ry   = SAMPLE_WIDTH'($urandom);
                case (kind)
                    // tiny vectors, coarse angles
                    0: begin
                        rx = SAMPLE_WIDTH'(int'($urandom_range(0, 16)) - 8);
                        ry = SAMPLE_WIDTH'(int'($urandom_range(0, 16)) - 8);
                    end
                    // on an axis
                    1: begin
                        if ($urandom_range(0, 1)) rx = '0;
                        else ry = '0;
                    end
                    // diagonal, any quadrant
                    2: begin
                        ry = $urandom_range(0, 1) ? rx : -rx;
                    end
                    // just off an axis
                    3: begin
                        ry = SAMPLE_WIDTH'(int'($urandom_range(0, 6)) - 3);
                        if ($urandom_range(0, 1)) begin
                            swap = rx;
                            rx   = ry;
                            ry   = swap;
                        end
                    end
                    default: begin
                    end
                endcase
                send_sample(rx, ry, PREDICT);
            end
        end
        i_s_tvalid <= 1'b0;

        wait (heading_queue.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // run limit
    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/chd_pkg.sv
rtl/chd_cordic_pipe.sv
rtl/compass_heading_degrees.sv
sim/compass_heading_degrees_tb.sv
